/* hw/rtl/tsc_pkg.sv */
// Package for the thermostat setpoint controller.
// Holds register map codes, reset values and the result type; no dependencies.
package tsc_pkg;

  localparam int unsigned TempW    = 8;
  localparam int unsigned MarginW  = 6;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] REG_MARGIN       = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MIN_SETPOINT = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_SETPOINT = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TIMEOUT      = 3'd3;
  localparam logic [RegIdxW-1:0] REG_INIT_SETPT   = 3'd4;

  localparam logic [MarginW-1:0] MARGIN_RST       = 6'd4;
  localparam logic [TempW-1:0]   MIN_SETPOINT_RST = 8'd35;
  localparam logic [TempW-1:0]   MAX_SETPOINT_RST = 8'd75;
  localparam logic [TempW-1:0]   TIMEOUT_RST      = 8'd26;
  localparam logic [TempW-1:0]   INIT_SETPT_RST   = 8'd60;
  localparam logic [TempW-1:0]   IDLE_MAX         = 8'd255;

  typedef struct packed {
    logic             heat_drive;
    logic             cool_drive;
    logic             in_setting;
    logic             power_enabled;
    logic [TempW-1:0] shown_temp;
  } result_t;

endpackage

/* hw/rtl/thermostat_setpoint_controller_top.sv */
// Top level of the thermostat setpoint controller.
// Depends on tsc_pkg for register codes, reset values and the result type.
//
// Usage: each request on the tick channel (tick_valid, tick_stall and the
// button and temperature fields) is one control tick. It is accepted at a
// rising edge where tick_valid is high and tick_stall is low. Every request
// yields exactly one result on the result channel (result_valid,
// result_stall and the drive, mode and display fields), taken at an edge
// where result_valid is high and result_stall is low.
// The result is registered in the output register at the accepting edge, or
// in the skid register when the receiver stalls. Throughput is one request
// per cycle while tick_stall is low; the state update is one pass of compares
// and adds between the state registers and the output register.
// When the receiver stalls, the waiting result holds and one more request
// is still accepted into a skid register; tick_stall then rises until the
// receiver drains it.
// Reset (rst, synchronous, active high) clears power, the setting mode, the
// idle timer and the hysteresis locks, loads the setpoint with 60 and puts the
// configuration registers back to their defaults. The user must write registers
// over the APB port only while no request is in flight; this is not enforced.
module thermostat_setpoint_controller_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_stall,
  input  logic                      up_released,
  input  logic                      down_released,
  input  logic                      power_released,
  input  logic [tsc_pkg::TempW-1:0] mean_temp,
  input  logic [tsc_pkg::TempW-1:0] probe_temp,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      heat_drive,
  output logic                      cool_drive,
  output logic                      in_setting,
  output logic                      power_enabled,
  output logic [tsc_pkg::TempW-1:0] shown_temp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsc_pkg::AddrW-1:0] paddr,
  input  logic [tsc_pkg::DataW-1:0] pwdata,
  output logic [tsc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import tsc_pkg::*;

  logic [MarginW-1:0] margin;
  logic [TempW-1:0]   min_setpoint;
  logic [TempW-1:0]   max_setpoint;
  logic [TempW-1:0]   setting_timeout;
  logic [TempW-1:0]   initial_setpoint;

  logic [TempW-1:0]   setpoint;
  logic [TempW-1:0]   setpoint_next;
  logic               setting_active;
  logic               setting_active_next;
  logic [TempW-1:0]   idle_ticks;
  logic [TempW-1:0]   idle_ticks_next;
  logic               control_on;
  logic               control_on_next;
  logic               heat_lock;
  logic               heat_lock_next;
  logic               cool_lock;
  logic               cool_lock_next;

  result_t            result_next;
  result_t            out_reg;
  result_t            skid_reg;
  logic               skid_valid;

  logic               cfg_write;
  logic [RegIdxW-1:0] reg_idx;
  logic               tick_accept;
  logic               result_take;

  logic signed [TempW+1:0] sp_adj;
  logic               restart;
  logic [TempW-1:0]   idle_tmp;
  logic [TempW:0]     avg_plus_m;
  logic [TempW:0]     sp_plus_m;
  logic               temp_low;
  logic               temp_high;

  assign pready      = 1'b1;
  assign reg_idx     = paddr[AddrW-1:2];
  assign cfg_write   = psel && penable && pwrite && pready;
  assign tick_stall  = skid_valid;
  assign tick_accept = tick_valid && !tick_stall;
  assign result_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin           <= MARGIN_RST;
      min_setpoint     <= MIN_SETPOINT_RST;
      max_setpoint     <= MAX_SETPOINT_RST;
      setting_timeout  <= TIMEOUT_RST;
      initial_setpoint <= INIT_SETPT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MARGIN:       margin           <= pwdata[MarginW-1:0];
        REG_MIN_SETPOINT: min_setpoint     <= pwdata[TempW-1:0];
        REG_MAX_SETPOINT: max_setpoint     <= pwdata[TempW-1:0];
        REG_TIMEOUT:      setting_timeout  <= pwdata[TempW-1:0];
        REG_INIT_SETPT:   initial_setpoint <= pwdata[TempW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MARGIN:       prdata = DataW'(margin);
      REG_MIN_SETPOINT: prdata = DataW'(min_setpoint);
      REG_MAX_SETPOINT: prdata = DataW'(max_setpoint);
      REG_TIMEOUT:      prdata = DataW'(setting_timeout);
      REG_INIT_SETPT:   prdata = DataW'(initial_setpoint);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    // Net raise and lower, then limit to the maximum and raise to the minimum.
    sp_adj = $signed({2'b00, setpoint})
           + $signed({{(TempW+1){1'b0}}, setting_active && up_released})
           - $signed({{(TempW+1){1'b0}}, setting_active && down_released});
    if (sp_adj > $signed({2'b00, max_setpoint})) begin
      sp_adj = $signed({2'b00, max_setpoint});
    end
    if (sp_adj < $signed({2'b00, min_setpoint})) begin
      sp_adj = $signed({2'b00, min_setpoint});
    end
    setpoint_next = sp_adj[TempW-1:0];

    restart             = 1'b0;
    setting_active_next = setting_active;
    if (up_released || down_released) begin
      if (!setting_active) begin
        setting_active_next = 1'b1;
      end else begin
        restart = 1'b1;
      end
    end

    result_next.shown_temp = setting_active_next ? setpoint_next : probe_temp;

    idle_ticks_next = idle_ticks;
    if (setting_active_next) begin
      idle_tmp = (restart && (idle_ticks < setting_timeout)) ? '0 : idle_ticks;
      if (idle_tmp >= setting_timeout) begin
        setting_active_next = 1'b0;
        idle_ticks_next     = '0;
      end else if (idle_tmp < IDLE_MAX) begin
        idle_ticks_next = idle_tmp + 1'b1;
      end else begin
        idle_ticks_next = idle_tmp;
      end
    end else begin
      idle_tmp = idle_ticks;
    end

    control_on_next = control_on ^ power_released;

    avg_plus_m = {1'b0, mean_temp} + {{(TempW+1-MarginW){1'b0}}, margin};
    sp_plus_m  = {1'b0, setpoint_next} + {{(TempW+1-MarginW){1'b0}}, margin};
    temp_low   = avg_plus_m < {1'b0, setpoint_next};
    temp_high  = {1'b0, mean_temp} > sp_plus_m;

    heat_lock_next = heat_lock;
    cool_lock_next = cool_lock;
    if (control_on_next) begin
      if (!cool_lock_next) begin
        if (temp_low && !heat_lock_next) begin
          heat_lock_next = 1'b1;
        end
        if (temp_high && heat_lock_next) begin
          heat_lock_next = 1'b0;
        end
      end
      if (!heat_lock_next) begin
        if (temp_high && !cool_lock_next) begin
          cool_lock_next = 1'b1;
        end
        if (temp_low && cool_lock_next) begin
          cool_lock_next = 1'b0;
        end
      end
    end else begin
      heat_lock_next = 1'b0;
      cool_lock_next = 1'b0;
    end

    result_next.heat_drive    = control_on_next && heat_lock_next;
    result_next.cool_drive    = control_on_next && cool_lock_next;
    result_next.in_setting    = setting_active_next;
    result_next.power_enabled = control_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= INIT_SETPT_RST;
      setting_active <= 1'b0;
      idle_ticks     <= '0;
      control_on     <= 1'b0;
      heat_lock      <= 1'b0;
      cool_lock      <= 1'b0;
    end else if (tick_accept) begin
      setpoint       <= setpoint_next;
      setting_active <= setting_active_next;
      idle_ticks     <= idle_ticks_next;
      control_on     <= control_on_next;
      heat_lock      <= heat_lock_next;
      cool_lock      <= cool_lock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (result_take) begin
          skid_valid <= 1'b0;
        end
      end else if (tick_accept) begin
        if (result_valid && !result_take) begin
          skid_valid <= 1'b1;
        end else begin
          result_valid <= 1'b1;
        end
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_take) begin
        out_reg <= skid_reg;
      end
    end else if (tick_accept) begin
      if (result_valid && !result_take) begin
        skid_reg <= result_next;
      end else begin
        out_reg <= result_next;
      end
    end
  end

  assign heat_drive    = out_reg.heat_drive;
  assign cool_drive    = out_reg.cool_drive;
  assign in_setting    = out_reg.in_setting;
  assign power_enabled = out_reg.power_enabled;
  assign shown_temp    = out_reg.shown_temp;

endmodule

/* bench/thermostat_setpoint_controller_top_tb.sv */
// Self-checking testbench for thermostat_setpoint_controller_top.
// Needs tsc_pkg and the top level. The bench drives directed and random ticks
// under several register settings; a shadow model predicts every control tick.
`timescale 1ns / 100ps

module thermostat_setpoint_controller_top_tb;
  import tsc_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  class thermo_shadow;
    logic [MarginW-1:0] margin;
    logic [TempW-1:0]   min_sp;
    logic [TempW-1:0]   max_sp;
    logic [TempW-1:0]   timeout;
    logic [TempW-1:0]   init_sp;
    logic [TempW-1:0]   setpoint;
    logic [TempW-1:0]   idle;
    logic               in_mode;
    logic               powered;
    logic               heat;
    logic               cool;
    result_t            due[$];
    int                 errors;
    int                 ticks;
    int                 exits;
    int                 heat_ticks;
    int                 cool_ticks;

    function void reset_state();
      margin   = MARGIN_RST;
      min_sp   = MIN_SETPOINT_RST;
      max_sp   = MAX_SETPOINT_RST;
      timeout  = TIMEOUT_RST;
      init_sp  = INIT_SETPT_RST;
      setpoint = init_sp;
      idle     = '0;
      in_mode  = 1'b0;
      powered  = 1'b0;
      heat     = 1'b0;
      cool     = 1'b0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [7:0] value);
      case (idx)
        REG_MARGIN:       margin  = value[MarginW-1:0];
        REG_MIN_SETPOINT: min_sp  = value;
        REG_MAX_SETPOINT: max_sp  = value;
        REG_TIMEOUT:      timeout = value;
        REG_INIT_SETPT:   init_sp = value;
        default: ;
      endcase
    endfunction

    function void note_tick(logic up, logic dn, logic pw, logic [TempW-1:0] avg,
                            logic [TempW-1:0] sensed);
      int      sp;
      logic    restart;
      logic    low;
      logic    high;
      result_t r;
      restart = 1'b0;
      sp = int'(setpoint);
      if (in_mode && up) sp = sp + 1;
      if (in_mode && dn) sp = sp - 1;
      if (sp > int'(max_sp)) sp = int'(max_sp);
      if (sp < int'(min_sp)) sp = int'(min_sp);
      setpoint = sp[7:0];
      if (up || dn) begin
        if (!in_mode) in_mode = 1'b1;
        else restart = 1'b1;
      end
      r.shown_temp = in_mode ? setpoint : sensed;
      if (in_mode) begin
        if (restart && idle < timeout) idle = '0;
        if (idle >= timeout) begin
          in_mode = 1'b0;
          idle = '0;
          exits++;
        end else if (idle != IDLE_MAX) begin
          idle = idle + 8'd1;
        end
      end
      if (pw) powered = !powered;
      if (powered) begin
        low  = int'(avg) + int'(margin) < int'(setpoint);
        high = int'(avg) > int'(setpoint) + int'(margin);
        if (!cool) begin
          if (low && !heat) heat = 1'b1;
          if (high && heat) heat = 1'b0;
        end
        if (!heat) begin
          if (high && !cool) cool = 1'b1;
          if (low && cool) cool = 1'b0;
        end
      end else begin
        heat = 1'b0;
        cool = 1'b0;
      end
      r.heat_drive    = powered && heat;
      r.cool_drive    = powered && cool;
      r.in_setting    = in_mode;
      r.power_enabled = powered;
      if (r.heat_drive) heat_ticks++;
      if (r.cool_drive) cool_ticks++;
      due.push_back(r);
      ticks++;
    endfunction

    function void check_output(logic h, logic c, logic s, logic p, logic [TempW-1:0] t);
      result_t want;
      if (due.size() == 0) begin
        $error("Result arrived with no tick waiting.");
        errors++;
        return;
      end
      want = due.pop_front();
      if (h !== want.heat_drive) begin
        $error("heat_drive: expected %0b, got %0b", want.heat_drive, h);
        errors++;
      end
      if (c !== want.cool_drive) begin
        $error("cool_drive: expected %0b, got %0b", want.cool_drive, c);
        errors++;
      end
      if (s !== want.in_setting) begin
        $error("in_setting: expected %0b, got %0b", want.in_setting, s);
        errors++;
      end
      if (p !== want.power_enabled) begin
        $error("power_enabled: expected %0b, got %0b", want.power_enabled, p);
        errors++;
      end
      if (t !== want.shown_temp) begin
        $error("shown_temp: expected %0d, got %0d", want.shown_temp, t);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             tick_valid;
  logic             tick_stall;
  logic             up_released;
  logic             down_released;
  logic             power_released;
  logic [TempW-1:0] mean_temp;
  logic [TempW-1:0] probe_temp;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic             heat_drive;
  logic             cool_drive;
  logic             in_setting;
  logic             power_enabled;
  logic [TempW-1:0] shown_temp;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  thermo_shadow sb;
  logic         gap_on = 1'b1;
  logic         stall_on = 1'b1;
  int           stall_left = 0;
  int           settings = 0;
  int unsigned  cycle_cnt = 0;

  thermostat_setpoint_controller_top u_top (
    .clk           (clk),
    .rst           (rst),
    .tick_valid    (tick_valid),
    .tick_stall    (tick_stall),
    .up_released   (up_released),
    .down_released (down_released),
    .power_released(power_released),
    .mean_temp     (mean_temp),
    .probe_temp    (probe_temp),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .heat_drive    (heat_drive),
    .cool_drive    (cool_drive),
    .in_setting    (in_setting),
    .power_enabled (power_enabled),
    .shown_temp    (shown_temp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_output(heat_drive, cool_drive, in_setting, power_enabled, shown_temp);
  end

  task automatic send_tick(logic up, logic dn, logic pw, logic [TempW-1:0] avg,
                           logic [TempW-1:0] sensed);
    @(negedge clk);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      tick_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    tick_valid     = 1'b1;
    up_released    = up;
    down_released  = dn;
    power_released = pw;
    mean_temp      = avg;
    probe_temp     = sensed;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    sb.note_tick(up, dn, pw, avg, sensed);
  endtask

  task automatic settle();
    @(negedge clk);
    tick_valid = 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [7:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = DataW'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_all(logic [7:0] m, logic [7:0] lo, logic [7:0] hi, logic [7:0] tmo,
                           logic [7:0] init);
    write_reg(REG_MARGIN, m);
    write_reg(REG_MIN_SETPOINT, lo);
    write_reg(REG_MAX_SETPOINT, hi);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_INIT_SETPT, init);
    settings++;
  endtask

  task automatic random_settings();
    logic [7:0] m;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] tmo;
    m = 8'($urandom_range(0, 63));
    if ($urandom_range(0, 3) == 0) m = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd63;
    lo = 8'($urandom_range(0, 160));
    hi = 8'($urandom_range(96, 255));
    if ($urandom_range(0, 5) == 0) begin
      lo = 8'($urandom);
      hi = 8'($urandom);
    end
    tmo = 8'($urandom_range(0, 12));
    if ($urandom_range(0, 7) == 0) tmo = 8'($urandom);
    write_all(m, lo, hi, tmo, 8'($urandom));
  endtask

  task automatic random_tick(int unsigned press_odds);
    int   span;
    int   a;
    logic up;
    logic dn;
    logic pw;
    up = ($urandom_range(0, press_odds) == 0);
    dn = ($urandom_range(0, press_odds) == 0);
    pw = ($urandom_range(0, 29) == 0);
    span = int'(sb.margin) + 3;
    a = int'(sb.setpoint) - span + int'($urandom_range(0, 2 * span));
    if (a < 0) a = 0;
    if (a > 255) a = 255;
    if ($urandom_range(0, 4) == 0) a = int'($urandom_range(0, 255));
    send_tick(up, dn, pw, 8'(a), 8'($urandom));
  endtask

  initial begin
    sb = new();
    rst            = 1'b1;
    tick_valid     = 1'b0;
    up_released    = 1'b0;
    down_released  = 1'b0;
    power_released = 1'b0;
    mean_temp      = '0;
    probe_temp     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sb.reset_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Power on, both lock handovers, then setpoint adjust at the reset settings.
    send_tick(1'b0, 1'b0, 1'b1, 8'd0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd255, 8'd255);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0, 8'h0F);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0, 8'hF0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd60, 8'hAA);
    send_tick(1'b1, 1'b0, 1'b0, 8'd60, 8'h55);
    send_tick(1'b1, 1'b0, 1'b0, 8'd70, 8'h55);
    send_tick(1'b1, 1'b1, 1'b0, 8'd50, 8'h55);
    send_tick(1'b0, 1'b1, 1'b0, 8'd60, 8'h55);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0, 8'h33);
    settle();

    // Minimum above maximum, widest margin and a zero timeout.
    write_all(8'd63, 8'd200, 8'd100, 8'd0, 8'd0);
    send_tick(1'b1, 1'b0, 1'b1, 8'd0, 8'h81);
    send_tick(1'b0, 1'b0, 1'b0, 8'd255, 8'h7E);
    send_tick(1'b1, 1'b0, 1'b0, 8'd136, 8'h01);
    send_tick(1'b0, 1'b0, 1'b0, 8'd137, 8'h80);
    settle();

    // Setpoint pinned at the top of the range.
    write_all(8'd0, 8'd255, 8'd255, 8'd2, 8'd255);
    send_tick(1'b1, 1'b0, 1'b0, 8'd255, 8'h12);
    send_tick(1'b1, 1'b0, 1'b0, 8'd0, 8'h34);
    send_tick(1'b0, 1'b0, 1'b0, 8'd255, 8'h56);
    send_tick(1'b0, 1'b0, 1'b0, 8'd255, 8'h78);
    settle();

    // Setpoint pinned at the bottom of the range.
    write_all(8'd0, 8'd0, 8'd0, 8'd255, 8'd128);
    send_tick(1'b0, 1'b1, 1'b0, 8'd1, 8'h9A);
    send_tick(1'b0, 1'b1, 1'b0, 8'd0, 8'hBC);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0, 8'hDE);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        write_all(8'd63, 8'd0, 8'd255, 8'd1, 8'd0);
      end else if (ph == 1) begin
        write_all(8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
      end else if (ph == 9) begin
        gap_on = 1'b0;
        stall_on = 1'b0;
        write_all(8'(MARGIN_RST), MIN_SETPOINT_RST, MAX_SETPOINT_RST, TIMEOUT_RST,
                  INIT_SETPT_RST);
      end else begin
        gap_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        random_settings();
      end
      for (int i = 0; i < 125; i++)
        random_tick($urandom_range(2, 12));
      settle();
    end
    repeat (4) @(posedge clk);

    $display("Checked %0d control ticks over %0d register settings.", sb.ticks, settings);
    $display("Setting mode timed out %0d times; heater on %0d ticks, cooler on %0d ticks.",
             sb.exits, sb.heat_ticks, sb.cool_ticks);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tsc_pkg.sv
hw/rtl/thermostat_setpoint_controller_top.sv
bench/thermostat_setpoint_controller_top_tb.sv
